@@ sv/splm_pkg.sv @@
// ----------------------------------------------------------------------------
// splm_pkg
// Shared types and constants for the stereo peak level meter.
// ----------------------------------------------------------------------------
package splm_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int FIELD_BITS    = 16;
    localparam int LEVEL_BITS    = 7;
    localparam int MS_BITS       = 16;
    localparam int PCT_MUL_BITS  = 7;
    localparam int PROD_BITS     = SAMPLE_BITS + PCT_MUL_BITS;
    localparam int PCT_RAW_BITS  = PROD_BITS - (SAMPLE_BITS - 1);
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [LEVEL_BITS-1:0]   FULL_PERCENT  = LEVEL_BITS'(100);
    localparam logic [LEVEL_BITS-1:0]   DECAY_STEP    = LEVEL_BITS'(4);
    localparam logic [MS_BITS-1:0]      MIN_WINDOW_MS = MS_BITS'(200);
    localparam logic [PCT_MUL_BITS-1:0] PCT_SCALE     = PCT_MUL_BITS'(100);

    // Register indexes, taken from paddr[2]
    localparam logic REG_CODEC_READY   = 1'b0;
    localparam logic REG_TEST_DURATION = 1'b1;

    typedef enum logic [1:0] {
        KIND_SAMPLE    = 2'd0,
        KIND_FRAME_END = 2'd1,
        KIND_TICK      = 2'd2,
        KIND_START     = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                         kind;
        logic signed [FIELD_BITS-1:0]  left_sample;
        logic signed [FIELD_BITS-1:0]  right_sample;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level_percent;
        logic                  window_active;
    } result_t;

    typedef struct packed {
        logic               codec_ready;
        logic [MS_BITS-1:0] test_duration_ms;
    } cfg_t;

endpackage

@@ sv/splm_lane.sv @@
// ----------------------------------------------------------------------------
// splm_lane
// Magnitude of one channel sample, taken from its low SAMPLE_BITS bits.
// ----------------------------------------------------------------------------
module splm_lane (
    input  logic signed [splm_pkg::FIELD_BITS-1:0]  sample,
    output logic        [splm_pkg::SAMPLE_BITS-1:0] magnitude
);
    import splm_pkg::*;

    logic [SAMPLE_BITS-1:0] raw;

    assign raw = sample[SAMPLE_BITS-1:0];

    // Full-scale negative wraps to 2^(SAMPLE_BITS-1), which is the true magnitude
    assign magnitude = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;

endmodule

@@ sv/splm_cfg.sv @@
// ----------------------------------------------------------------------------
// splm_cfg
// APB register file: codec ready flag and measurement window length.
// ----------------------------------------------------------------------------
module splm_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [splm_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [splm_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [splm_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output splm_pkg::cfg_t                     cfg
);
    import splm_pkg::*;

    logic               codec_ready_reg;
    logic [MS_BITS-1:0] duration_reg;
    logic               wr_en;
    logic               reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_ready_reg <= 1'b0;
            duration_reg    <= MIN_WINDOW_MS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CODEC_READY:   codec_ready_reg <= pwdata[0];
                REG_TEST_DURATION: duration_reg    <= pwdata[MS_BITS-1:0];
                default:           codec_ready_reg <= codec_ready_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CODEC_READY:   prdata = APB_DATA_BITS'(codec_ready_reg);
            REG_TEST_DURATION: prdata = APB_DATA_BITS'(duration_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.codec_ready      = codec_ready_reg;
    assign cfg.test_duration_ms = duration_reg;

endmodule

@@ sv/splm_core.sv @@
// ----------------------------------------------------------------------------
// splm_core
// Merges the lane magnitudes into the frame peak and updates level and window.
// ----------------------------------------------------------------------------
module splm_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             item_fire,
    input  splm_pkg::kind_t                  kind,
    input  logic [splm_pkg::SAMPLE_BITS-1:0] left_mag,
    input  logic [splm_pkg::SAMPLE_BITS-1:0] right_mag,
    input  splm_pkg::cfg_t                   cfg,
    output splm_pkg::result_t                result
);
    import splm_pkg::*;

    logic [LEVEL_BITS-1:0]   level_reg,   level_next;
    logic [SAMPLE_BITS-1:0]  peak_reg,    peak_next;
    logic                    has_smp_reg, has_smp_next;
    logic [MS_BITS-1:0]      remain_reg,  remain_next;

    logic                    active_now;
    logic                    active_next;
    logic [SAMPLE_BITS-1:0]  pair_max;
    logic [PROD_BITS-1:0]    product;
    logic [PCT_RAW_BITS-1:0] pct_raw;
    logic [LEVEL_BITS-1:0]   pct;
    logic [LEVEL_BITS+1:0]   blend;
    logic [MS_BITS-1:0]      window_len;

    assign active_now = cfg.codec_ready && (remain_reg != '0);
    assign pair_max   = (right_mag > left_mag) ? right_mag : left_mag;

    // Peak to percent: (peak * 100) >> (SAMPLE_BITS-1), clamp to 100
    assign product = PROD_BITS'(peak_reg) * PROD_BITS'(PCT_SCALE);
    assign pct_raw = product[PROD_BITS-1:SAMPLE_BITS-1];
    assign pct     = (pct_raw > PCT_RAW_BITS'(FULL_PERCENT)) ? FULL_PERCENT
                                                              : pct_raw[LEVEL_BITS-1:0];
    assign blend   = ({2'b00, level_reg} << 1) + {2'b00, level_reg} + {2'b00, pct};

    assign window_len = (cfg.test_duration_ms < MIN_WINDOW_MS) ? MIN_WINDOW_MS
                                                               : cfg.test_duration_ms;

    always_comb begin
        level_next   = level_reg;
        peak_next    = peak_reg;
        has_smp_next = has_smp_reg;
        remain_next  = remain_reg;
        case (kind)
            KIND_SAMPLE: begin
                if (active_now) begin
                    if (pair_max > peak_reg) begin
                        peak_next = pair_max;
                    end
                    has_smp_next = 1'b1;
                end
            end
            KIND_FRAME_END: begin
                if (!active_now) begin
                    level_next = '0;
                end else if (!has_smp_reg) begin
                    level_next = (level_reg > DECAY_STEP) ? level_reg - DECAY_STEP : '0;
                end else if (pct > level_reg) begin
                    level_next = pct;
                end else begin
                    level_next = blend[LEVEL_BITS+1:2];
                end
                peak_next    = '0;
                has_smp_next = 1'b0;
            end
            KIND_TICK: begin
                if (remain_reg != '0) begin
                    remain_next = remain_reg - MS_BITS'(1);
                end
            end
            KIND_START: begin
                if (cfg.codec_ready) begin
                    level_next  = '0;
                    remain_next = window_len;
                end
            end
            default: begin
                level_next = level_reg;
            end
        endcase
    end

    assign active_next          = cfg.codec_ready && (remain_next != '0);
    assign result.window_active = active_next;
    assign result.level_percent = active_next ? level_next : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg   <= '0;
            peak_reg    <= '0;
            has_smp_reg <= 1'b0;
            remain_reg  <= '0;
        end else if (item_fire) begin
            level_reg   <= level_next;
            peak_reg    <= peak_next;
            has_smp_reg <= has_smp_next;
            remain_reg  <= remain_next;
        end
    end

endmodule

@@ sv/splm_skid.sv @@
// ----------------------------------------------------------------------------
// splm_skid
// Two-entry output buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module splm_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  splm_pkg::result_t in_data,
    output logic              in_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output splm_pkg::result_t m_result
);
    import splm_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_free;

    assign in_ready = !skid_valid_reg;
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_result = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                // drain the skid beat first
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        if (!out_free && in_fire) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

@@ sv/stereo_peak_level_meter_unit.sv @@
// ----------------------------------------------------------------------------
// stereo_peak_level_meter_unit
// Stereo peak meter with fast attack, slow release and a timed test window.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (s_valid/s_ready, s_item) carry a kind and a stereo pair:
//   sample pair, frame end, one millisecond tick or start. Every accepted
//   beat yields exactly one result beat (m_valid/m_ready, m_result) with the
//   smoothed level in percent and the window-active flag after the update.
//   Two lanes take |left| and |right| side by side; the core merges them into
//   the frame peak and updates level and countdown in the same cycle.
//   Each result is registered in the output register, or in the skid one
//   when the receiver stalls. One item per cycle while s_ready is high.
//   Reset clears level, peak and countdown (window inactive), sets
//   codec_ready to 0 and the window length to 200 ms; no result is pending.
//   When the receiver stalls, one result waits in the output register and
//   one more in a skid register; s_ready drops only when both are full.
//   Write the APB registers (codec_ready at 0x0, test_duration_ms at 0x4)
//   only while the block is idle.
// ----------------------------------------------------------------------------
module stereo_peak_level_meter_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  splm_pkg::in_item_t                 s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output splm_pkg::result_t                  m_result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [splm_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [splm_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [splm_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import splm_pkg::*;

    cfg_t                   cfg;
    logic [SAMPLE_BITS-1:0] left_mag;
    logic [SAMPLE_BITS-1:0] right_mag;
    logic                   item_fire;
    result_t                core_result;

    assign item_fire = s_valid && s_ready;

    splm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    splm_lane u_lane_left (
        .sample    (s_item.left_sample),
        .magnitude (left_mag)
    );

    splm_lane u_lane_right (
        .sample    (s_item.right_sample),
        .magnitude (right_mag)
    );

    splm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (item_fire),
        .kind      (s_item.kind),
        .left_mag  (left_mag),
        .right_mag (right_mag),
        .cfg       (cfg),
        .result    (core_result)
    );

    splm_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (item_fire),
        .in_data  (core_result),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

endmodule
